>>> src/sgdmf_pkg.sv
// Shared types, constants and a helper function for the SGD matrix factorization update block.
// Used by the controller, the datapath and the top level.
package sgdmf_pkg;

	// Default sizes, handed to the top-level parameters.
	localparam int DEF_NUM_USERS    = 1024;
	localparam int DEF_NUM_ITEMS    = 1024;
	localparam int DEF_MAX_FEATURES = 32;

	// Field widths.
	localparam int OP_W   = 3;
	localparam int ROW_W  = 10;
	localparam int FIDX_W = 5;
	localparam int VAL_W  = 16;
	localparam int CNT_W  = 6;
	localparam int CFG_W  = 16;
	localparam int CIDX_W = 2;

	// Internal arithmetic widths.
	localparam int ACC_W  = 40;
	localparam int PF_W   = 49;
	localparam int EO_W   = 32;
	localparam int SUM_W  = 54;
	localparam int STEP_W = 22;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_WR_USER = 3'd0;
	localparam logic [OP_W-1:0] OP_WR_ITEM = 3'd1;
	localparam logic [OP_W-1:0] OP_TRAIN   = 3'd2;
	localparam logic [OP_W-1:0] OP_RD_USER = 3'd3;
	localparam logic [OP_W-1:0] OP_RD_ITEM = 3'd4;

	// Configuration register indexes.
	localparam logic [CIDX_W-1:0] REG_LR    = 2'd0;
	localparam logic [CIDX_W-1:0] REG_REG   = 2'd1;
	localparam logic [CIDX_W-1:0] REG_FCNT  = 2'd2;

	// Configuration reset values.
	localparam logic [CFG_W-1:0] LR_RESET   = 16'd655;
	localparam logic [CFG_W-1:0] REG_RESET  = 16'd3277;
	localparam logic [CNT_W-1:0] FCNT_RESET = 6'd32;

	// What the result beat carries.
	localparam logic [1:0] KIND_NONE   = 2'd0;
	localparam logic [1:0] KIND_READ_U = 2'd1;
	localparam logic [1:0] KIND_READ_I = 2'd2;
	localparam logic [1:0] KIND_TRAIN  = 2'd3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic             load;
		logic             wr_user;
		logic             wr_item;
		logic             rd_issue;
		logic             dot_issue;
		logic             upd_issue;
		logic             calc_err;
		logic             finish;
		logic [1:0]       kind;
		logic [CNT_W-1:0] k;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic             u_ok;
		logic             i_ok;
		logic             f_ok;
		logic [CNT_W-1:0] n;
	} sts_t;

	// Saturate a signed value to the 16-bit range.
	function automatic logic signed [VAL_W-1:0] sat16(input logic signed [ACC_W-1:0] x);
		logic signed [VAL_W-1:0] r;
		if (x > 40'sd32767) begin
			r = 16'sh7FFF;
		end else if (x < -40'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = x[VAL_W-1:0];
		end
		return r;
	endfunction

endpackage

>>> src/sgdmf_ctrl.sv
// Controller state machine for the SGD matrix factorization update block.
// Depends on sgdmf_pkg; drives the datapath through cmd_t and watches sts_t.
module sgdmf_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [sgdmf_pkg::OP_W-1:0]  operation,
	input  sgdmf_pkg::sts_t             sts,
	output sgdmf_pkg::cmd_t             cmd,
	output logic                        busy,
	output logic                        done
);
	import sgdmf_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_WR   = 4'd1;
	localparam logic [3:0] S_RD   = 4'd2;
	localparam logic [3:0] S_RDW  = 4'd3;
	localparam logic [3:0] S_DOT  = 4'd4;
	localparam logic [3:0] S_DW   = 4'd5;
	localparam logic [3:0] S_ERR  = 4'd6;
	localparam logic [3:0] S_UPD  = 4'd7;
	localparam logic [3:0] S_UDR  = 4'd8;

	logic [3:0]       state_q, state_d;
	logic [OP_W-1:0]  op_q, op_d;
	logic [CNT_W-1:0] k_q, k_d;
	logic [CNT_W-1:0] n_q, n_d;
	logic [1:0]       dcnt_q, dcnt_d;
	logic             done_d;

	// Next-state and command decode.
	always_comb begin
		state_d = state_q;
		op_d    = op_q;
		k_d     = k_q;
		n_d     = n_q;
		dcnt_d  = dcnt_q;
		done_d  = 1'b0;
		cmd     = '0;
		cmd.k   = k_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					op_d     = operation;
					k_d      = '0;
					n_d      = sts.n;
					case (operation)
						OP_WR_USER: begin
							if (sts.u_ok && sts.f_ok) state_d = S_WR;
							else begin
								cmd.finish = 1'b1;
								done_d     = 1'b1;
							end
						end
						OP_WR_ITEM: begin
							if (sts.i_ok && sts.f_ok) state_d = S_WR;
							else begin
								cmd.finish = 1'b1;
								done_d     = 1'b1;
							end
						end
						OP_RD_USER: begin
							if (sts.u_ok && sts.f_ok) state_d = S_RD;
							else begin
								cmd.finish = 1'b1;
								done_d     = 1'b1;
							end
						end
						OP_RD_ITEM: begin
							if (sts.i_ok && sts.f_ok) state_d = S_RD;
							else begin
								cmd.finish = 1'b1;
								done_d     = 1'b1;
							end
						end
						OP_TRAIN: begin
							if (sts.u_ok && sts.i_ok) state_d = S_DOT;
							else begin
								cmd.finish = 1'b1;
								done_d     = 1'b1;
							end
						end
						default: begin
							cmd.finish = 1'b1;
							done_d     = 1'b1;
						end
					endcase
				end
			end
			S_WR: begin
				cmd.wr_user = (op_q == OP_WR_USER);
				cmd.wr_item = (op_q == OP_WR_ITEM);
				cmd.finish  = 1'b1;
				done_d      = 1'b1;
				state_d     = S_IDLE;
			end
			S_RD: begin
				cmd.rd_issue = 1'b1;
				state_d      = S_RDW;
			end
			S_RDW: begin
				cmd.finish = 1'b1;
				cmd.kind   = (op_q == OP_RD_USER) ? KIND_READ_U : KIND_READ_I;
				done_d     = 1'b1;
				state_d    = S_IDLE;
			end
			S_DOT: begin
				if (k_q < n_q) begin
					cmd.dot_issue = 1'b1;
					k_d           = k_q + 1'b1;
				end else begin
					state_d = S_DW;
				end
			end
			S_DW: begin
				state_d = S_ERR;
			end
			S_ERR: begin
				cmd.calc_err = 1'b1;
				k_d          = '0;
				state_d      = S_UPD;
			end
			S_UPD: begin
				if (k_q < n_q) begin
					cmd.upd_issue = 1'b1;
					k_d           = k_q + 1'b1;
				end else begin
					dcnt_d  = 2'd2;
					state_d = S_UDR;
				end
			end
			S_UDR: begin
				if (dcnt_q == 2'd0) begin
					cmd.finish = 1'b1;
					cmd.kind   = KIND_TRAIN;
					done_d     = 1'b1;
					state_d    = S_IDLE;
				end else begin
					dcnt_d = dcnt_q - 1'b1;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done    <= 1'b0;
			op_q    <= '0;
			k_q     <= '0;
			n_q     <= '0;
			dcnt_q  <= '0;
		end else begin
			state_q <= state_d;
			done    <= done_d;
			op_q    <= op_d;
			k_q     <= k_d;
			n_q     <= n_d;
			dcnt_q  <= dcnt_d;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

>>> src/sgdmf_dp.sv
// Datapath of the SGD matrix factorization update block: feature stores, configuration
// registers, dot-product pipeline and update pipeline. Depends on sgdmf_pkg.
module sgdmf_dp #(
	parameter int NUM_USERS    = sgdmf_pkg::DEF_NUM_USERS,
	parameter int NUM_ITEMS    = sgdmf_pkg::DEF_NUM_ITEMS,
	parameter int MAX_FEATURES = sgdmf_pkg::DEF_MAX_FEATURES
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	input  logic [sgdmf_pkg::CIDX_W-1:0]       cfg_index,
	input  logic [sgdmf_pkg::CFG_W-1:0]        cfg_data,
	input  logic [sgdmf_pkg::ROW_W-1:0]        user_index,
	input  logic [sgdmf_pkg::ROW_W-1:0]        item_index,
	input  logic [sgdmf_pkg::FIDX_W-1:0]       feature_index,
	input  logic signed [sgdmf_pkg::VAL_W-1:0] value,
	input  sgdmf_pkg::cmd_t                    cmd,
	output sgdmf_pkg::sts_t                    sts,
	output logic signed [sgdmf_pkg::VAL_W-1:0] read_value,
	output logic signed [sgdmf_pkg::VAL_W-1:0] prediction,
	output logic signed [sgdmf_pkg::VAL_W-1:0] rating_error
);
	import sgdmf_pkg::*;

	localparam int U_DEPTH = NUM_USERS * MAX_FEATURES;
	localparam int I_DEPTH = NUM_ITEMS * MAX_FEATURES;
	localparam int UA_W    = (U_DEPTH > 1) ? $clog2(U_DEPTH) : 1;
	localparam int IA_W    = (I_DEPTH > 1) ? $clog2(I_DEPTH) : 1;

	// Configuration registers.
	logic [CFG_W-1:0] lr_q, reg_q;
	logic [CNT_W-1:0] fcnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q   <= LR_RESET;
			reg_q  <= REG_RESET;
			fcnt_q <= FCNT_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_LR:   lr_q   <= cfg_data;
				REG_REG:  reg_q  <= cfg_data;
				REG_FCNT: fcnt_q <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Range checks on the offered beat and the clamped feature count.
	always_comb begin
		sts.u_ok = (32'(user_index) < NUM_USERS);
		sts.i_ok = (32'(item_index) < NUM_ITEMS);
		sts.f_ok = (32'(feature_index) < MAX_FEATURES);
		sts.n    = (32'(fcnt_q) > MAX_FEATURES) ? CNT_W'(MAX_FEATURES) : fcnt_q;
	end

	// Latched operands.
	logic [ROW_W-1:0]        uidx_q, iidx_q;
	logic [FIDX_W-1:0]       fidx_q;
	logic signed [VAL_W-1:0] val_q;
	logic [2*CFG_W-1:0]      lrreg_q;

	// Pipeline registers.
	logic                    dot_s1, upd_s1, dot_s2, upd_s2, upd_s3, upd_s4;
	logic [CNT_W-1:0]        k_s1, k_s2, k_s3, k_s4;
	logic signed [VAL_W-1:0] rdu_q, rdi_q;
	logic signed [EO_W-1:0]  prod_s2;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [VAL_W-1:0] pred_q, err_q;
	logic signed [EO_W-1:0]  eo_u_s2, eo_i_s2;
	logic signed [PF_W-1:0]  pf_u_s2, pf_i_s2, pf_u_s3, pf_i_s3;
	logic signed [PF_W-1:0]  q_u_s3, q_i_s3;
	logic signed [VAL_W-1:0] f_u_s2, f_i_s2, f_u_s3, f_i_s3, f_u_s4, f_i_s4;
	logic signed [STEP_W-1:0] step_u_s4, step_i_s4;

	// Store addressing.
	logic [UA_W-1:0]         ura, uwa;
	logic [IA_W-1:0]         ira, iwa;
	logic [CNT_W-1:0]        rcol, wcol;
	logic                    uwe, iwe;
	logic signed [VAL_W-1:0] uwd, iwd;
	logic signed [SUM_W-1:0] sum_u, sum_i;
	logic signed [ACC_W-1:0] pred_full;
	logic signed [VAL_W-1:0] pred_d;

	always_comb begin
		rcol = cmd.rd_issue ? CNT_W'(fidx_q) : cmd.k;
		wcol = upd_s4 ? k_s4 : CNT_W'(fidx_q);
		ura  = UA_W'(UA_W'(uidx_q) * UA_W'(MAX_FEATURES)) + UA_W'(rcol);
		ira  = IA_W'(IA_W'(iidx_q) * IA_W'(MAX_FEATURES)) + IA_W'(rcol);
		uwa  = UA_W'(UA_W'(uidx_q) * UA_W'(MAX_FEATURES)) + UA_W'(wcol);
		iwa  = IA_W'(IA_W'(iidx_q) * IA_W'(MAX_FEATURES)) + IA_W'(wcol);
		uwe  = cmd.wr_user | upd_s4;
		iwe  = cmd.wr_item | upd_s4;
		uwd  = upd_s4 ? sat16(ACC_W'(f_u_s4) - ACC_W'(step_u_s4)) : val_q;
		iwd  = upd_s4 ? sat16(ACC_W'(f_i_s4) - ACC_W'(step_i_s4)) : val_q;
	end

	// Feature stores with registered reads.
	logic signed [VAL_W-1:0] umem [U_DEPTH];
	logic signed [VAL_W-1:0] imem [I_DEPTH];

	always_ff @(posedge clk) begin
		if (uwe) umem[uwa] <= uwd;
		rdu_q <= umem[ura];
	end

	always_ff @(posedge clk) begin
		if (iwe) imem[iwa] <= iwd;
		rdi_q <= imem[ira];
	end

	// Pipeline valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_s1 <= 1'b0;
			dot_s2 <= 1'b0;
			upd_s1 <= 1'b0;
			upd_s2 <= 1'b0;
			upd_s3 <= 1'b0;
			upd_s4 <= 1'b0;
		end else begin
			dot_s1 <= cmd.dot_issue;
			dot_s2 <= dot_s1;
			upd_s1 <= cmd.upd_issue;
			upd_s2 <= upd_s1;
			upd_s3 <= upd_s2;
			upd_s4 <= upd_s3;
		end
	end

	// Prediction from the accumulated dot product, and the sums for the update step.
	always_comb begin
		pred_full = acc_q >>> 12;
		pred_d    = sat16(pred_full);
		sum_u     = SUM_W'(pf_u_s3) + (SUM_W'(q_u_s3) <<< 4);
		sum_i     = SUM_W'(pf_i_s3) + (SUM_W'(q_i_s3) <<< 4);
	end

	// Operand latch, dot-product accumulation and update arithmetic.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			uidx_q  <= user_index;
			iidx_q  <= item_index;
			fidx_q  <= feature_index;
			val_q   <= value;
			lrreg_q <= lr_q * reg_q;
		end
		if (cmd.load) begin
			acc_q <= '0;
		end else if (dot_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
		if (cmd.calc_err) begin
			pred_q <= pred_d;
			err_q  <= sat16(ACC_W'(pred_d) - ACC_W'(val_q));
		end
		k_s1 <= cmd.k;
		k_s2 <= k_s1;
		k_s3 <= k_s2;
		k_s4 <= k_s3;
		// Stage 2: products of the read pair.
		prod_s2 <= rdu_q * rdi_q;
		eo_u_s2 <= err_q * rdi_q;
		eo_i_s2 <= err_q * rdu_q;
		pf_u_s2 <= $signed({1'b0, lrreg_q}) * rdu_q;
		pf_i_s2 <= $signed({1'b0, lrreg_q}) * rdi_q;
		f_u_s2  <= rdu_q;
		f_i_s2  <= rdi_q;
		// Stage 3: scale the error term by the learning rate.
		q_u_s3  <= PF_W'($signed({1'b0, lr_q}) * eo_u_s2);
		q_i_s3  <= PF_W'($signed({1'b0, lr_q}) * eo_i_s2);
		pf_u_s3 <= pf_u_s2;
		pf_i_s3 <= pf_i_s2;
		f_u_s3  <= f_u_s2;
		f_i_s3  <= f_i_s2;
		// Stage 4: floor the step to Q10.12.
		step_u_s4 <= STEP_W'(sum_u >>> 32);
		step_i_s4 <= STEP_W'(sum_i >>> 32);
		f_u_s4    <= f_u_s3;
		f_i_s4    <= f_i_s3;
	end

	// Result registers, loaded when the controller finishes an operation.
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			case (cmd.kind)
				KIND_READ_U: read_value <= rdu_q;
				KIND_READ_I: read_value <= rdi_q;
				default:     read_value <= '0;
			endcase
			prediction   <= (cmd.kind == KIND_TRAIN) ? pred_q : '0;
			rating_error <= (cmd.kind == KIND_TRAIN) ? err_q : '0;
		end
	end

endmodule

>>> src/sgd_matrix_factorization_update.sv
// Top level of the SGD matrix factorization update block: controller plus datapath.
// Depends on sgdmf_pkg, sgdmf_ctrl and sgdmf_dp.
//
//   channel   handshake              beat
//   command   start, busy            operation, user_index, item_index, feature_index, value
//   result    done (one cycle)       read_value, prediction, rating_error
//   config    cfg_valid, cfg_ready   cfg_index, cfg_data
//
// A train does one read per cycle through the store read port for the dot product, then
// one read-modify-write per cycle through a four-stage update pipeline. Reset clears
// control and configuration, not the stores.
// The result beat cannot be stalled; the next command may start while it is shown.
module sgd_matrix_factorization_update #(
	parameter int NUM_USERS    = sgdmf_pkg::DEF_NUM_USERS,
	parameter int NUM_ITEMS    = sgdmf_pkg::DEF_NUM_ITEMS,
	parameter int MAX_FEATURES = sgdmf_pkg::DEF_MAX_FEATURES
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [sgdmf_pkg::OP_W-1:0]         operation,
	input  logic [sgdmf_pkg::ROW_W-1:0]        user_index,
	input  logic [sgdmf_pkg::ROW_W-1:0]        item_index,
	input  logic [sgdmf_pkg::FIDX_W-1:0]       feature_index,
	input  logic signed [sgdmf_pkg::VAL_W-1:0] value,
	output logic                               done,
	output logic signed [sgdmf_pkg::VAL_W-1:0] read_value,
	output logic signed [sgdmf_pkg::VAL_W-1:0] prediction,
	output logic signed [sgdmf_pkg::VAL_W-1:0] rating_error,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [sgdmf_pkg::CIDX_W-1:0]       cfg_index,
	input  logic [sgdmf_pkg::CFG_W-1:0]        cfg_data
);
	import sgdmf_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic start_ok;

	// Configuration writes are always taken.
	assign cfg_ready = 1'b1;
	assign start_ok  = start & ~busy;

	sgdmf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start_ok),
		.operation (operation),
		.sts       (sts),
		.cmd       (cmd),
		.busy      (busy),
		.done      (done)
	);

	sgdmf_dp #(
		.NUM_USERS    (NUM_USERS),
		.NUM_ITEMS    (NUM_ITEMS),
		.MAX_FEATURES (MAX_FEATURES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.user_index    (user_index),
		.item_index    (item_index),
		.feature_index (feature_index),
		.value         (value),
		.cmd           (cmd),
		.sts           (sts),
		.read_value    (read_value),
		.prediction    (prediction),
		.rating_error  (rating_error)
	);

`ifndef SYNTHESIS
	// Leaving a multi-cycle operation always shows its result beat.
	a_fall_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy fell without a result beat");

	// A read result never carries train fields.
	a_read_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && read_value != '0) |-> (prediction == '0 && rating_error == '0))
		else $error("read result carries train fields");

	// An unknown operation answers at once with all fields zero.
	a_bad_op: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && operation != OP_WR_USER && operation != OP_WR_ITEM &&
		 operation != OP_TRAIN && operation != OP_RD_USER && operation != OP_RD_ITEM)
		|=> (done && !busy && read_value == '0 && prediction == '0 &&
		     rating_error == '0))
		else $error("unknown operation not answered with zeros");
`endif

endmodule
